@@ sv/move_outline_segment_generator_unit_assert.svh @@
// Assertion macros for the RTL of the move-outline segment generator.
// Modules that check their own logic include this file; it needs clk_i and rst_ni in scope.
`ifndef MOVE_OUTLINE_SEGMENT_GENERATOR_UNIT_ASSERT_SVH
`define MOVE_OUTLINE_SEGMENT_GENERATOR_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// A property that must hold at every clock edge outside of reset.
`define MOSG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("mosg assertion failed");
// A condition that must never be true outside of reset.
`define MOSG_ASSERT_NEVER(lbl, cond) `MOSG_ASSERT(lbl, !(cond))
`else
`define MOSG_ASSERT(lbl, prop)
`define MOSG_ASSERT_NEVER(lbl, cond)
`endif

`endif

@@ sv/mosg_pkg.sv @@
// Types and constants of the move-outline segment generator.
// Used by the front, back and top level; depends on nothing else.
`timescale 1ns / 1ps

package mosg_pkg;

  // Reciprocal of three scaled by 2^17, exact for magnitudes below 2^15.
  localparam logic [15:0] RecipThird = 16'hAAAB;
  localparam int unsigned RecipShift = 17;

  // One outline rectangle as it arrives and as it is kept.
  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [14:0] w;
    logic [14:0] h;
    logic [7:0]  bw;
    logic [9:0]  th;
  } rect_t;

  // Work handed from the front to the back for one changed input.
  typedef struct packed {
    rect_t old_rect;
    rect_t new_rect;
    logic  do_erase;
    logic  do_draw;
  } job_t;

  // One result segment.
  typedef struct packed {
    logic [15:0] x1;
    logic [15:0] y1;
    logic [15:0] x2;
    logic [15:0] y2;
    logic        erase;
    logic        last;
  } seg_t;

  // Back-end sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CALC = 4'b0010,
    ST_MUL  = 4'b0100,
    ST_EMIT = 4'b1000
  } back_state_e;

  // Segment order within one outline.
  typedef enum logic [3:0] {
    SEG_TOP    = 4'd0,
    SEG_BOTTOM = 4'd1,
    SEG_LEFT   = 4'd2,
    SEG_RIGHT  = 4'd3,
    SEG_VERT1  = 4'd4,
    SEG_VERT2  = 4'd5,
    SEG_HORZ1  = 4'd6,
    SEG_HORZ2  = 4'd7,
    SEG_TITLE  = 4'd8
  } seg_sel_e;

endpackage

@@ sv/mosg_fifo.sv @@
// Small first-in first-out queue with full and empty flags.
// Generic in width and depth; used for the job queue and the result queue.
`timescale 1ns / 1ps

module mosg_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             push_ok, pop_ok;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i & ~full_o;
  assign pop_ok  = pop_i & ~empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Storage is written on each push transfer.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_ok, pop_ok})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

@@ sv/mosg_front.sv @@
// Front end: accepts outline rectangles, keeps the last one and classifies changes.
// Depends on mosg_pkg; feeds jobs into the job queue.
`timescale 1ns / 1ps

module mosg_front
  import mosg_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        job_full_i,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [14:0] rect_width_i,
  input  logic [14:0] rect_height_i,
  input  logic [7:0]  border_width_i,
  input  logic [9:0]  title_height_i,
  output logic        job_push_o,
  output job_t        job_o
);

  rect_t new_rect;
  rect_t prev_q;
  logic  accept, unchanged;

  assign new_rect.x  = pos_x_i;
  assign new_rect.y  = pos_y_i;
  assign new_rect.w  = rect_width_i;
  assign new_rect.h  = rect_height_i;
  assign new_rect.bw = border_width_i;
  assign new_rect.th = title_height_i;

  assign accept    = push_i & ~job_full_i;
  assign unchanged = (new_rect == prev_q);

  // A job names which of the two outlines have a size and must be drawn.
  assign job_o.old_rect = prev_q;
  assign job_o.new_rect = new_rect;
  assign job_o.do_erase = (prev_q.w != '0) || (prev_q.h != '0);
  assign job_o.do_draw  = (new_rect.w != '0) || (new_rect.h != '0);
  assign job_push_o     = accept & ~unchanged & (job_o.do_erase | job_o.do_draw);

  // The kept rectangle follows every accepted input.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
    end else if (accept) begin
      prev_q <= new_rect;
    end
  end

endmodule

@@ sv/mosg_back.sv @@
// Back end: turns one job into its erase run and draw run, one segment per cycle while the result queue has room.
// Depends on mosg_pkg and the assertion header; feeds the result queue.
`timescale 1ns / 1ps
`include "move_outline_segment_generator_unit_assert.svh"

module mosg_back
  import mosg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic job_empty_i,
  input  job_t job_i,
  output logic job_pop_o,
  input  logic seg_full_i,
  output logic seg_push_o,
  output seg_t seg_o
);

  localparam int unsigned WrapBits = (COORD_BITS < 16) ? COORD_BITS : 16;

  // Wrap a coordinate to the configured width and sign-extend it to 16 bits.
  function automatic logic [15:0] wrap_coord(input logic [15:0] v);
    logic [15:0] r;
    for (int i = 0; i < 16; i++) begin
      r[i] = (i < WrapBits) ? v[i] : v[WrapBits-1];
    end
    return r;
  endfunction

  back_state_e state_q, state_d;
  logic        phase_erase_q, phase_erase_d;
  logic [3:0]  seg_q, seg_d;
  job_t        job_q;
  rect_t       cur;

  // Geometry of the current outline.
  logic [15:0] xl_q, xr_q, yt_q, yb_q, il_q, ir_q, it_q, ib_q, ytt_q;
  logic [14:0] magx_q, magy_q;
  logic        negx_q, negy_q, title_on_q;
  logic [15:0] tx_q, ty_q;

  logic [15:0] w16, h16, bw16, th16;
  logic [15:0] xr_c, yb_c, ytt_c;
  logic [16:0] dx_c, dy_c, absx_c, absy_c;
  logic [30:0] prodx_c, prody_c;
  logic [15:0] tx_c, ty_c;
  logic [15:0] vx1, vx2, hy1, hy2;
  logic [15:0] cx1, cy1, cx2, cy2;
  logic        final_seg;

  assign cur  = phase_erase_q ? job_q.old_rect : job_q.new_rect;
  assign w16  = {1'b0, cur.w};
  assign h16  = {1'b0, cur.h};
  assign bw16 = {8'b0, cur.bw};
  assign th16 = {6'b0, cur.th};

  // Edge positions, modulo 2^16, and the inner extents to be split in thirds.
  assign xr_c   = cur.x + w16 - 16'd1;
  assign yb_c   = cur.y + h16 - 16'd1;
  assign ytt_c  = cur.y + th16;
  assign dx_c   = {2'b0, cur.w} - 17'd1 - {8'b0, cur.bw, 1'b0};
  assign dy_c   = {2'b0, cur.h} - 17'd1 - {8'b0, cur.bw, 1'b0} - {7'b0, cur.th};
  assign absx_c = dx_c[16] ? (17'd0 - dx_c) : dx_c;
  assign absy_c = dy_c[16] ? (17'd0 - dy_c) : dy_c;

  // Thirds by reciprocal multiplication; sign restored for truncation toward zero.
  assign prodx_c = {16'b0, magx_q} * {15'b0, RecipThird};
  assign prody_c = {16'b0, magy_q} * {15'b0, RecipThird};
  assign tx_c = negx_q ? (16'd0 - {2'b0, prodx_c[30:RecipShift]})
                       : {2'b0, prodx_c[30:RecipShift]};
  assign ty_c = negy_q ? (16'd0 - {2'b0, prody_c[30:RecipShift]})
                       : {2'b0, prody_c[30:RecipShift]};

  // Third lines of the current outline.
  assign vx1 = il_q + tx_q;
  assign vx2 = il_q + {tx_q[14:0], 1'b0};
  assign hy1 = it_q + ty_q;
  assign hy2 = it_q + {ty_q[14:0], 1'b0};

  // Segment end points for the current step.
  always_comb begin
    cx1 = xl_q;
    cy1 = yt_q;
    cx2 = xr_q;
    cy2 = yt_q;
    case (seg_sel_e'(seg_q))
      SEG_TOP: begin
        cx1 = xl_q; cy1 = yt_q; cx2 = xr_q; cy2 = yt_q;
      end
      SEG_BOTTOM: begin
        cx1 = xl_q; cy1 = yb_q; cx2 = xr_q; cy2 = yb_q;
      end
      SEG_LEFT: begin
        cx1 = xl_q; cy1 = yt_q; cx2 = xl_q; cy2 = yb_q;
      end
      SEG_RIGHT: begin
        cx1 = xr_q; cy1 = yt_q; cx2 = xr_q; cy2 = yb_q;
      end
      SEG_VERT1: begin
        cx1 = vx1; cy1 = it_q; cx2 = vx1; cy2 = ib_q;
      end
      SEG_VERT2: begin
        cx1 = vx2; cy1 = it_q; cx2 = vx2; cy2 = ib_q;
      end
      SEG_HORZ1: begin
        cx1 = il_q; cy1 = hy1; cx2 = ir_q; cy2 = hy1;
      end
      SEG_HORZ2: begin
        cx1 = il_q; cy1 = hy2; cx2 = ir_q; cy2 = hy2;
      end
      SEG_TITLE: begin
        cx1 = xl_q; cy1 = ytt_q; cx2 = xr_q; cy2 = ytt_q;
      end
      default: begin
        cx1 = xl_q; cy1 = yt_q; cx2 = xr_q; cy2 = yt_q;
      end
    endcase
  end

  assign final_seg = title_on_q ? (seg_q == SEG_TITLE) : (seg_q == SEG_HORZ2);

  assign seg_o.x1    = wrap_coord(cx1);
  assign seg_o.y1    = wrap_coord(cy1);
  assign seg_o.x2    = wrap_coord(cx2);
  assign seg_o.y2    = wrap_coord(cy2);
  assign seg_o.erase = phase_erase_q;
  assign seg_o.last  = final_seg & (~phase_erase_q | ~job_q.do_draw);

  assign job_pop_o  = (state_q == ST_IDLE) & ~job_empty_i;
  assign seg_push_o = (state_q == ST_EMIT) & ~seg_full_i;

  // Sequencer: load a job, set up the geometry, then step through the segments.
  always_comb begin
    state_d       = state_q;
    phase_erase_d = phase_erase_q;
    seg_d         = seg_q;
    case (state_q)
      ST_IDLE: begin
        if (!job_empty_i) begin
          phase_erase_d = job_i.do_erase;
          state_d       = ST_CALC;
        end
      end
      ST_CALC: begin
        state_d = ST_MUL;
      end
      ST_MUL: begin
        seg_d   = SEG_TOP;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (seg_push_o) begin
          if (final_seg) begin
            if (phase_erase_q && job_q.do_draw) begin
              phase_erase_d = 1'b0;
              state_d       = ST_CALC;
            end else begin
              state_d = ST_IDLE;
            end
          end else begin
            seg_d = seg_q + 4'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      phase_erase_q <= 1'b0;
      seg_q         <= SEG_TOP;
    end else begin
      state_q       <= state_d;
      phase_erase_q <= phase_erase_d;
      seg_q         <= seg_d;
    end
  end

  // Job and geometry registers.
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (state_q == ST_CALC) begin
      xl_q       <= cur.x;
      xr_q       <= xr_c;
      yt_q       <= cur.y;
      yb_q       <= yb_c;
      il_q       <= cur.x + bw16;
      ir_q       <= xr_c - bw16;
      ytt_q      <= ytt_c;
      it_q       <= ytt_c + bw16;
      ib_q       <= yb_c - bw16;
      magx_q     <= absx_c[14:0];
      magy_q     <= absy_c[14:0];
      negx_q     <= dx_c[16];
      negy_q     <= dy_c[16];
      title_on_q <= (cur.th != '0);
    end
    if (state_q == ST_MUL) begin
      tx_q <= tx_c;
      ty_q <= ty_c;
    end
  end

  `MOSG_ASSERT(a_seg_in_range, (state_q == ST_EMIT) |-> (seg_q <= SEG_TITLE))
  `MOSG_ASSERT_NEVER(a_title_needs_height, (state_q == ST_EMIT) && (seg_q == SEG_TITLE) && !title_on_q)
  `MOSG_ASSERT(a_erase_then_draw, (seg_push_o && final_seg && phase_erase_q && job_q.do_draw) |=> ((state_q == ST_CALC) && !phase_erase_q))
  `MOSG_ASSERT_NEVER(a_last_on_final_only, seg_push_o && seg_o.last && !final_seg)
  `MOSG_ASSERT(a_pop_starts_setup, job_pop_o |=> (state_q == ST_CALC))

endmodule

@@ sv/move_outline_segment_generator_unit.sv @@
// Move-outline segment generator: input stage, job queue, segment sequencer, result queue.
// Depends on mosg_pkg, mosg_fifo, mosg_front and mosg_back.
//
// Usage: an outline rectangle is transferred in when push is high and full is low.
// An input equal to the kept rectangle causes no segment. Otherwise the old outline
// (if it had a size) is sent as an erase run and the new one (if it has a size) as a
// draw run, eight segments each plus a title separator when the title height is set.
// A result is on the seg ports while empty is low and is transferred when pop is high.
// last_seg marks the final segment caused by one input.
// The back end loads a job in its idle state, then sets up each outline in a calculation
// state (edges) and a multiply state (the divide by three, one multiplier per axis) and
// emits one segment per cycle while the result queue has room. The front and two job
// slots keep taking inputs meanwhile; throughput is set by the back-end sequencer.
// Reset clears the kept rectangle to zero (no outline) and empties both queues.
// When the receiver stalls, the result queue fills, the sequencer holds, and full
// rises once the job queue is full.
`timescale 1ns / 1ps

module move_outline_segment_generator_unit
  import mosg_pkg::*;
#(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [15:0] pos_x_i,
  input  logic [15:0] pos_y_i,
  input  logic [14:0] rect_width_i,
  input  logic [14:0] rect_height_i,
  input  logic [7:0]  border_width_i,
  input  logic [9:0]  title_height_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] seg_x1_o,
  output logic [15:0] seg_y1_o,
  output logic [15:0] seg_x2_o,
  output logic [15:0] seg_y2_o,
  output logic        erase_flag_o,
  output logic        last_seg_o
);

  localparam int unsigned JobDepth = 2;
  localparam int unsigned SegDepth = 2;

  job_t job_in, job_out;
  seg_t seg_in, seg_out;
  logic job_push, job_empty, job_pop;
  logic seg_push, seg_full;

  // Input stage.
  mosg_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push),
    .job_full_i     (full),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .border_width_i (border_width_i),
    .title_height_i (title_height_i),
    .job_push_o     (job_push),
    .job_o          (job_in)
  );

  // Job queue between front and back.
  mosg_fifo #(
    .Width ($bits(job_t)),
    .Depth (JobDepth)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  // Segment sequencer.
  mosg_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .seg_full_i  (seg_full),
    .seg_push_o  (seg_push),
    .seg_o       (seg_in)
  );

  // Result queue toward the receiver.
  mosg_fifo #(
    .Width ($bits(seg_t)),
    .Depth (SegDepth)
  ) u_seg_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (seg_push),
    .data_i  (seg_in),
    .full_o  (seg_full),
    .pop_i   (pop),
    .data_o  (seg_out),
    .empty_o (empty)
  );

  assign seg_x1_o     = seg_out.x1;
  assign seg_y1_o     = seg_out.y1;
  assign seg_x2_o     = seg_out.x2;
  assign seg_y2_o     = seg_out.y2;
  assign erase_flag_o = seg_out.erase;
  assign last_seg_o   = seg_out.last;

endmodule

@@ test/tb_move_outline_segment_generator_unit.sv @@
// Self-checking testbench for the move-outline segment generator: directed and random rectangles.
// Depends on mosg_pkg and move_outline_segment_generator_unit, with the files that the unit needs.
`timescale 1ns / 1ps

module tb_move_outline_segment_generator_unit;
  import mosg_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned N_RANDOM = 250;
  localparam int unsigned MAX_IDLE = 14;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned N_DIRECTED = 22;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        push;
  logic        full;
  logic [15:0] pos_x_i;
  logic [15:0] pos_y_i;
  logic [14:0] rect_width_i;
  logic [14:0] rect_height_i;
  logic [7:0]  border_width_i;
  logic [9:0]  title_height_i;
  logic        empty;
  logic        pop;
  logic [15:0] seg_x1_o;
  logic [15:0] seg_y1_o;
  logic [15:0] seg_x2_o;
  logic [15:0] seg_y2_o;
  logic        erase_flag_o;
  logic        last_seg_o;

  // Kept rectangle of the predictor, segments of one move, and segments still owed by the block.
  rect_t kept_rect;
  seg_t  move_segs [0:17];
  int    move_len;
  seg_t  pending_segs [$];

  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned seg_count = 0;

  // Directed rectangles: x, y, width, height, border, title, number of segments they cause.
  int move_table [N_DIRECTED][7] = '{
    '{0, 0, 0, 0, 0, 0, 0},
    '{5, 0, 0, 0, 0, 0, 0},
    '{5, 0, 0, 0, 0, 0, 0},
    '{0, 0, 1, 1, 0, 0, 8},
    '{0, 0, 1, 1, 0, 0, 0},
    '{0, 0, 1, 1, 0, 1, 17},
    '{32767, 32767, 32767, 32767, 255, 1023, 18},
    '{-32768, -32768, 32767, 32767, 255, 1023, 18},
    '{-32768, -32768, 0, 0, 255, 1023, 9},
    '{0, 0, 0, 5, 0, 0, 8},
    '{0, 0, 5, 0, 0, 0, 16},
    '{100, 100, 3, 3, 255, 1023, 17},
    '{100, 100, 7, 7, 1, 0, 17},
    '{100, 100, 2, 2, 5, 0, 16},
    '{100, 100, 2, 2, 6, 0, 16},
    '{100, 100, 10, 40, 6, 4, 17},
    '{-1, -1, 32767, 1, 0, 0, 17},
    '{-1, -1, 0, 0, 0, 0, 8},
    '{-1, -1, 0, 0, 0, 0, 0},
    '{32767, -32768, 16384, 16384, 128, 512, 9},
    '{32767, -32768, 16384, 16384, 128, 512, 0},
    '{32767, -32768, 16384, 16384, 128, 0, 17}
  };

  move_outline_segment_generator_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .rect_width_i   (rect_width_i),
    .rect_height_i  (rect_height_i),
    .border_width_i (border_width_i),
    .title_height_i (title_height_i),
    .empty          (empty),
    .pop            (pop),
    .seg_x1_o       (seg_x1_o),
    .seg_y1_o       (seg_y1_o),
    .seg_x2_o       (seg_x2_o),
    .seg_y2_o       (seg_y2_o),
    .erase_flag_o   (erase_flag_o),
    .last_seg_o     (last_seg_o)
  );

  always #1 clk_i = ~clk_i;

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[move_outline_segment_generator_unit] ERROR");
      $finish;
    end
  end

  // Append one segment; coordinates wrap to 16-bit two's complement.
  function automatic void add_segment(longint x1, longint y1, longint x2, longint y2,
                                      logic erase);
    move_segs[move_len] = '{x1: x1[15:0], y1: y1[15:0], x2: x2[15:0], y2: y2[15:0],
                            erase: erase, last: 1'b0};
    move_len++;
  endfunction

  // Append the segments of one outline: edges, thirds and the title separator.
  function automatic void add_outline(rect_t r, logic erase);
    longint xl, xr, yt, yb, il, ir, it, ib, tx, ty, th;
    if (r.w == 0 && r.h == 0) return;
    th = longint'(r.th);
    xl = longint'($signed(r.x));
    yt = longint'($signed(r.y));
    xr = xl + longint'(r.w) - 1;
    yb = yt + longint'(r.h) - 1;
    il = xl + longint'(r.bw);
    ir = xr - longint'(r.bw);
    it = yt + th + longint'(r.bw);
    ib = yb - longint'(r.bw);
    // Signed division truncates toward zero, also for a negative inner extent.
    tx = (ir - il) / 3;
    ty = (ib - it) / 3;
    add_segment(xl, yt, xr, yt, erase);
    add_segment(xl, yb, xr, yb, erase);
    add_segment(xl, yt, xl, yb, erase);
    add_segment(xr, yt, xr, yb, erase);
    add_segment(il + tx, it, il + tx, ib, erase);
    add_segment(il + 2 * tx, it, il + 2 * tx, ib, erase);
    add_segment(il, it + ty, ir, it + ty, erase);
    add_segment(il, it + 2 * ty, ir, it + 2 * ty, erase);
    if (th != 0) add_segment(xl, yt + th, xr, yt + th, erase);
  endfunction

  // Predict the erase and draw runs of one accepted rectangle and queue them.
  function automatic int predict_move(rect_t r);
    move_len = 0;
    if (r != kept_rect) begin
      add_outline(kept_rect, 1'b1);
      kept_rect = r;
      add_outline(kept_rect, 1'b0);
    end
    if (move_len > 0) move_segs[move_len - 1].last = 1'b1;
    for (int i = 0; i < move_len; i++) pending_segs.push_back(move_segs[i]);
    return move_len;
  endfunction

  // Random rectangle: mostly small sizes, with repeats, empty outlines and one-field changes.
  function automatic rect_t random_rect(rect_t prev);
    rect_t r;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    r.x = 16'($urandom);
    r.y = 16'($urandom);
    r.w = 15'($urandom_range(1, 64));
    r.h = 15'($urandom_range(1, 64));
    r.bw = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
    r.th = ($urandom_range(0, 2) == 0) ? 10'd0 : 10'($urandom_range(1, 20));
    if (pick < 12) begin
      r = prev;
    end else if (pick < 22) begin
      r.w = '0;
      r.h = '0;
    end else if (pick < 30) begin
      if (pick[0]) r.w = '0;
      else r.h = '0;
    end else if (pick < 45) begin
      r = prev;
      case ($urandom_range(0, 5))
        0: r.x = 16'($urandom);
        1: r.y = 16'($urandom);
        2: r.w = 15'($urandom);
        3: r.h = 15'($urandom);
        4: r.bw = 8'($urandom);
        default: r.th = 10'($urandom);
      endcase
    end else if (pick < 60) begin
      r.w = 15'($urandom);
      r.h = 15'($urandom);
      r.bw = 8'($urandom);
      r.th = 10'($urandom);
    end
    return r;
  endfunction

  // Transfer one rectangle after an idle gap, then predict its segments.
  task automatic send_rect(rect_t r, int unsigned gap, output int n_segs);
    repeat (gap) begin
      @(negedge clk_i);
      push <= 1'b0;
    end
    @(negedge clk_i);
    push <= 1'b1;
    pos_x_i <= r.x;
    pos_y_i <= r.y;
    rect_width_i <= r.w;
    rect_height_i <= r.h;
    border_width_i <= r.bw;
    title_height_i <= r.th;
    do @(posedge clk_i); while (full);
    n_segs = predict_move(r);
  endtask

  task automatic wait_drained();
    while (pending_segs.size() != 0) @(posedge clk_i);
  endtask

  function automatic void check_field(string name, logic [15:0] expected, logic [15:0] actual);
    if (actual !== expected) begin
      $error("%s: expected %0d, got %0d", name, $signed(expected), $signed(actual));
      err_count++;
    end
  endfunction

  // Compare one transferred segment with the oldest one owed.
  task automatic check_segment();
    seg_t exp_seg;
    if (pending_segs.size() == 0) begin
      $error("segment (%0d,%0d)-(%0d,%0d) with none expected", $signed(seg_x1_o),
             $signed(seg_y1_o), $signed(seg_x2_o), $signed(seg_y2_o));
      err_count++;
    end else begin
      exp_seg = pending_segs.pop_front();
      check_field("seg_x1", exp_seg.x1, seg_x1_o);
      check_field("seg_y1", exp_seg.y1, seg_y1_o);
      check_field("seg_x2", exp_seg.x2, seg_x2_o);
      check_field("seg_y2", exp_seg.y2, seg_y2_o);
      check_field("erase_flag", 16'(exp_seg.erase), 16'(erase_flag_o));
      check_field("last_seg", 16'(exp_seg.last), 16'(last_seg_o));
    end
  endtask

  // Result side: random stalls, with stretches of back-to-back transfers.
  initial begin
    int unsigned stall;
    pop = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = ((seg_count / 40) % 4 == 2) ? 0 : $urandom_range(0, MAX_IDLE);
      repeat (stall) begin
        @(negedge clk_i);
        pop <= 1'b0;
      end
      @(negedge clk_i);
      pop <= 1'b1;
      do @(posedge clk_i); while (empty);
      check_segment();
      seg_count++;
    end
  end

  // Input side: reset, directed table, random rectangles, then drain.
  initial begin
    rect_t r;
    int n_segs;
    int unsigned gap;
    rst_ni = 1'b0;
    push = 1'b0;
    pos_x_i = '0;
    pos_y_i = '0;
    rect_width_i = '0;
    rect_height_i = '0;
    border_width_i = '0;
    title_height_i = '0;
    kept_rect = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows carry the number of segments they must cause.
    for (int i = 0; i < N_DIRECTED; i++) begin
      r.x = 16'(move_table[i][0]);
      r.y = 16'(move_table[i][1]);
      r.w = 15'(move_table[i][2]);
      r.h = 15'(move_table[i][3]);
      r.bw = 8'(move_table[i][4]);
      r.th = 10'(move_table[i][5]);
      send_rect(r, $urandom_range(0, MAX_IDLE), n_segs);
      if (n_segs != move_table[i][6]) begin
        $error("row %0d: expected %0d segments, predicted %0d", i, move_table[i][6], n_segs);
        err_count++;
      end
    end
    wait_drained();

    // Random rectangles; one pause in the middle lets the block run dry.
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 2) wait_drained();
      gap = ((i / 30) % 4 == 3) ? 0 : $urandom_range(0, MAX_IDLE);
      send_rect(random_rect(kept_rect), gap, n_segs);
    end
    @(negedge clk_i);
    push <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("[move_outline_segment_generator_unit] OK");
    end else begin
      $display("[move_outline_segment_generator_unit] ERROR");
    end
    $finish;
  end

endmodule

@@ move_outline_segment_generator_unit.f @@
+incdir+sv
sv/mosg_pkg.sv
sv/mosg_fifo.sv
sv/mosg_front.sv
sv/mosg_back.sv
sv/move_outline_segment_generator_unit.sv
test/tb_move_outline_segment_generator_unit.sv
